### rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg: shared definitions for the set-associative LRU cache model
// Sizes of the line store, field widths, operation codes, register indexes
// and the layout of the response data word.
// ----------------------------------------------------------------------------
package salc_pkg;

   // Store geometry.
   localparam int MAX_SET_BITS  = 6;
   localparam int MAX_WAYS      = 8;
   localparam int ADDRESS_WIDTH = 64;
   localparam int NUM_SETS      = 1 << MAX_SET_BITS;
   localparam int SET_W         = MAX_SET_BITS;
   localparam int WAY_W         = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_W        = WAY_W;
   localparam int TAG_W         = ADDRESS_WIDTH;
   localparam int SB_W          = $clog2(MAX_SET_BITS + 1);
   localparam int WAYS_EFF_W    = $clog2(MAX_WAYS + 1);

   // Configuration register widths.
   localparam int SET_BITS_W   = 3;
   localparam int WAYS_CFG_W   = 4;
   localparam int BLOCK_BITS_W = 6;
   localparam int CSR_DATA_W   = 6;
   localparam int CSR_INDEX_W  = 2;
   localparam int SHIFT_W      = BLOCK_BITS_W + 1;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_BITS = 2'd2;

   // Reset values of the registers.
   localparam logic [SET_BITS_W-1:0]   SET_BITS_RESET   = 3'd4;
   localparam logic [WAYS_CFG_W-1:0]   WAYS_RESET       = 4'd1;
   localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RESET = 6'd4;

   // Access kinds.
   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_STORE  = 2'd1,
      OP_MODIFY = 2'd2,
      OP_FETCH  = 2'd3
   } op_type;

   // One way of a set as it sits in the memory row.
   typedef struct packed {
      logic              valid;
      logic [TAG_W-1:0]  tag;
      logic [RANK_W-1:0] rank;
   } way_type;

   typedef way_type [MAX_WAYS-1:0] row_type;

   localparam int ROW_W = $bits(row_type);

   // Response data layout, lowest bit first.
   localparam int RSP_HIT_BIT    = 0;
   localparam int RSP_MISS_BIT   = 1;
   localparam int RSP_EVICT_BIT  = 2;
   localparam int RSP_ADDED_LO   = 3;
   localparam int RSP_HITS_LO    = 5;
   localparam int RSP_MISSES_LO  = 37;
   localparam int RSP_EVICTS_LO  = 69;
   localparam int RSP_USED_W     = 101;
   localparam int RSP_W          = 104;
   localparam int REQ_W          = 64;

endpackage

### rtl/salc_ram.sv
// ----------------------------------------------------------------------------
// salc_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/set_assoc_lru_cache_model.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model: set-associative cache model with LRU replacement
// Looks up each access in a memory of sets, updates recency and counters.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on the req_ stream: req_tuser carries the access kind and
//   req_tdata the 64-bit byte address. Every load, store or modify produces
//   one transaction on the rsp_ stream with hit, miss and eviction flags, the
//   hits counted by this access and the three running totals. Instruction
//   fetches are accepted and dropped without a response.
//   The set is read from a synchronous memory in the cycle a request is
//   accepted, all ways are compared in the lookup state, and the updated
//   set is written back in the cycle the response is registered, once the
//   output register is free. A new request is taken only after the lookup
//   of the previous one has finished; a fetch does not leave the idle
//   state. The set row read and write back set this pace.
//   The response sits in an output register, so a request can be accepted
//   while the previous response still waits. If the receiver stalls, the
//   lookup holds its read data and finishes once the output register frees.
//   Reset (synchronous, active high) restores the register defaults, clears
//   the counters and marks every set empty through one flag per set, so no
//   clearing pass runs. A write to any of the three registers empties all
//   sets the same way and keeps the counters; the unused index is ignored.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model
   import salc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_W-1:0]       req_tdata,  // [63:0] address
   input  logic [1:0]             req_tuser,  // [1:0] op
   // Response stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] hit, [1] miss, [2] eviction, [4:3] hits_added, [36:5] total_hits,
   // [68:37] total_misses, [100:69] total_evictions, [103:101] zero
   output logic [RSP_W-1:0]       rsp_tdata,
   // Configuration write port.
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic {
      ST_IDLE,
      ST_LOOK
   } state_type;

   // Control and configuration state.
   state_type               state_ff, state_in;
   logic [SET_BITS_W-1:0]   set_bits_ff, set_bits_in;
   logic [WAYS_CFG_W-1:0]   ways_ff, ways_in;
   logic [BLOCK_BITS_W-1:0] block_bits_ff, block_bits_in;
   logic [NUM_SETS-1:0]     set_ok_ff, set_ok_in;

   // Request held during the lookup.
   logic [SET_W-1:0]        set_idx_ff, set_idx_in;
   logic [TAG_W-1:0]        tag_ff, tag_in;
   logic                    modify_ff, modify_in;
   logic                    row_ok_ff, row_ok_in;

   // Counters and response register.
   logic [31:0]             hit_total_ff, hit_total_in;
   logic [31:0]             miss_total_ff, miss_total_in;
   logic [31:0]             evict_total_ff, evict_total_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic                    rsp_evict_ff, rsp_evict_in;
   logic [1:0]              rsp_added_ff, rsp_added_in;

   // Address split for the incoming request.
   logic [SB_W-1:0]         sb_eff;
   logic [SHIFT_W-1:0]      shift_sum;
   logic [ADDRESS_WIDTH-1:0] req_addr;
   logic [ADDRESS_WIDTH-1:0] addr_shifted;
   logic [SET_W-1:0]        set_mask;
   logic [SET_W-1:0]        req_set;
   logic [TAG_W-1:0]        req_tag;
   logic                    req_accept;
   logic                    out_free;

   // Lookup signals.
   logic [WAYS_EFF_W-1:0]   ways_eff;
   logic [ROW_W-1:0]        rd_data;
   row_type                 row_q;
   row_type                 cur_row;
   row_type                 new_row;
   logic [MAX_WAYS-1:0]     lane_en;
   logic                    found_ok, empty_ok, oldest_ok;
   logic [WAY_W-1:0]        found_idx, empty_idx, oldest_idx, target;
   logic [RANK_W-1:0]       oldest_rank, old_rank;
   logic                    was_valid;
   logic                    lk_hit, lk_evict;
   logic [1:0]              lk_added;
   logic                    finish;

   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign finish     = (state_ff == ST_LOOK) && out_free;

   // Split of the address with the clamped set-bit count.
   always_comb begin
      req_addr     = req_tdata[ADDRESS_WIDTH-1:0];
      sb_eff       = (set_bits_ff > SET_BITS_W'(MAX_SET_BITS)) ?
                     SB_W'(MAX_SET_BITS) : SB_W'(set_bits_ff);
      shift_sum    = SHIFT_W'(sb_eff) + SHIFT_W'(block_bits_ff);
      addr_shifted = req_addr >> block_bits_ff;
      set_mask     = SET_W'((32'd1 << sb_eff) - 32'd1);
      req_set      = addr_shifted[SET_W-1:0] & set_mask;
      req_tag      = (shift_sum >= SHIFT_W'(ADDRESS_WIDTH)) ? '0 : (req_addr >> shift_sum);
   end

   // The set memory: one row holds every way of a set.
   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (finish),
      .wr_addr (set_idx_ff),
      .wr_data (new_row),
      .rd_en   (req_accept),
      .rd_addr (req_set),
      .rd_data (rd_data)
   );

   // Way search and recency update over the row read from memory. A set
   // whose flag is clear reads as all ways invalid with rank zero.
   always_comb begin
      if (ways_ff == '0) begin
         ways_eff = WAYS_EFF_W'(1);
      end else if (ways_ff > WAYS_CFG_W'(MAX_WAYS)) begin
         ways_eff = WAYS_EFF_W'(MAX_WAYS);
      end else begin
         ways_eff = WAYS_EFF_W'(ways_ff);
      end

      row_q   = row_type'(rd_data);
      cur_row = row_ok_ff ? row_q : '0;

      found_ok    = 1'b0;
      found_idx   = '0;
      empty_ok    = 1'b0;
      empty_idx   = '0;
      oldest_ok   = 1'b0;
      oldest_idx  = '0;
      oldest_rank = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         lane_en[w] = (WAYS_EFF_W'(w) < ways_eff);
         if (lane_en[w]) begin
            if (cur_row[w].valid) begin
               if (cur_row[w].tag == tag_ff) begin
                  if (!found_ok) begin
                     found_ok  = 1'b1;
                     found_idx = WAY_W'(w);
                  end
               end else if (!oldest_ok || (cur_row[w].rank > oldest_rank)) begin
                  oldest_ok   = 1'b1;
                  oldest_idx  = WAY_W'(w);
                  oldest_rank = cur_row[w].rank;
               end
            end else if (!empty_ok) begin
               empty_ok  = 1'b1;
               empty_idx = WAY_W'(w);
            end
         end
      end

      lk_hit   = found_ok;
      lk_evict = !found_ok && !empty_ok;
      if (found_ok) begin
         target = found_idx;
      end else if (empty_ok) begin
         target = empty_idx;
      end else begin
         target = oldest_idx;
      end
      was_valid = !lk_hit && empty_ok ? 1'b0 : 1'b1;
      old_rank  = cur_row[target].rank;

      new_row = cur_row;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (lane_en[w] && (WAY_W'(w) != target) && cur_row[w].valid &&
             (!was_valid || (cur_row[w].rank < old_rank)) &&
             (cur_row[w].rank < RANK_MAX)) begin
            new_row[w].rank = cur_row[w].rank + RANK_W'(1);
         end
      end
      new_row[target].rank  = '0;
      new_row[target].valid = 1'b1;
      if (!lk_hit) begin
         new_row[target].tag = tag_ff;
      end

      lk_added = {1'b0, lk_hit} + {1'b0, modify_ff};
   end

   // Next-state logic.
   always_comb begin
      state_in       = state_ff;
      set_bits_in    = set_bits_ff;
      ways_in        = ways_ff;
      block_bits_in  = block_bits_ff;
      set_ok_in      = set_ok_ff;
      set_idx_in     = set_idx_ff;
      tag_in         = tag_ff;
      modify_in      = modify_ff;
      row_ok_in      = row_ok_ff;
      hit_total_in   = hit_total_ff;
      miss_total_in  = miss_total_ff;
      evict_total_in = evict_total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_evict_in   = rsp_evict_ff;
      rsp_added_in   = rsp_added_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (op_type'(req_tuser) != OP_FETCH)) begin
               state_in   = ST_LOOK;
               set_idx_in = req_set;
               tag_in     = req_tag;
               modify_in  = (op_type'(req_tuser) == OP_MODIFY);
               row_ok_in  = set_ok_ff[req_set];
            end
         end
         ST_LOOK: begin
            if (out_free) begin
               state_in              = ST_IDLE;
               set_ok_in[set_idx_ff] = 1'b1;
               hit_total_in          = hit_total_ff + 32'(lk_added);
               miss_total_in         = miss_total_ff + 32'(!lk_hit);
               evict_total_in        = evict_total_ff + 32'(lk_evict);
               rsp_valid_in          = 1'b1;
               rsp_hit_in            = lk_hit;
               rsp_evict_in          = lk_evict;
               rsp_added_in          = lk_added;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A write to one of the three registers empties every set; a write to
      // the unused index changes nothing.
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SET_BITS: begin
               set_bits_in = csr_wdata[SET_BITS_W-1:0];
               set_ok_in   = '0;
            end
            CSR_WAYS: begin
               ways_in   = csr_wdata[WAYS_CFG_W-1:0];
               set_ok_in = '0;
            end
            CSR_BLOCK_BITS: begin
               block_bits_in = csr_wdata[BLOCK_BITS_W-1:0];
               set_ok_in     = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         set_bits_ff    <= SET_BITS_RESET;
         ways_ff        <= WAYS_RESET;
         block_bits_ff  <= BLOCK_BITS_RESET;
         set_ok_ff      <= '0;
         hit_total_ff   <= '0;
         miss_total_ff  <= '0;
         evict_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         set_bits_ff    <= set_bits_in;
         ways_ff        <= ways_in;
         block_bits_ff  <= block_bits_in;
         set_ok_ff      <= set_ok_in;
         hit_total_ff   <= hit_total_in;
         miss_total_ff  <= miss_total_in;
         evict_total_ff <= evict_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      set_idx_ff   <= set_idx_in;
      tag_ff       <= tag_in;
      modify_ff    <= modify_in;
      row_ok_ff    <= row_ok_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_evict_ff <= rsp_evict_in;
      rsp_added_ff <= rsp_added_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - RSP_USED_W)'(0), evict_total_ff, miss_total_ff,
                        hit_total_ff, rsp_added_ff, rsp_evict_ff, !rsp_hit_ff,
                        rsp_hit_ff};

endmodule

### rtl/salc_checker.sv
// ----------------------------------------------------------------------------
// salc_checker: port-level assertions for the cache model
// Watches the response stream over time and is bound to the top level.
// ----------------------------------------------------------------------------
module salc_checker
   import salc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_W-1:0]       rsp_tdata
);

   // A stalled response transaction holds its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // A response is either a hit or a miss, never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_HIT_BIT] != rsp_tdata[RSP_MISS_BIT]))
      else $error("hit and miss flags disagree");

   // Only a miss can evict a line.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_EVICT_BIT] |-> rsp_tdata[RSP_MISS_BIT])
      else $error("eviction reported on a hit");

   // A hit always counts at least one hit, and at most two are counted.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_ADDED_LO+1:RSP_ADDED_LO] != 2'd3) &&
                     (!rsp_tdata[RSP_HIT_BIT] ||
                      (rsp_tdata[RSP_ADDED_LO+1:RSP_ADDED_LO] != 2'd0)))
      else $error("hits added out of range");

   // Reset drops any pending response.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind set_assoc_lru_cache_model salc_checker u_salc_checker (.*);

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: randomized check of the set-associative LRU cache model
// Sends load, store, modify and fetch transactions through the request stream
// under many cache geometries. A cache mirror in the testbench predicts every
// response, including the hit, miss and eviction flags and the running totals.
// Both stream sides stall at random, and the response side is held off long
// enough to back the block up.
// ----------------------------------------------------------------------------
module tb;
   import salc_pkg::*;

   // The register index that no register answers to. A write there must leave
   // the configuration and the stored lines alone.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   localparam int NUM_LINES        = NUM_SETS * MAX_WAYS;
   localparam int NUM_PHASES       = 10;
   localparam int LONG_HOLD_CYCLES = 150;
   // Extra wait after the last predicted response, before registers are
   // written or the run ends.
   localparam int DRAIN_CYCLES     = 4;
   localparam int END_CYCLES       = 10;
   localparam int LIMIT_TIME       = 4_000_000;
   localparam int MAX_REPORTS      = 10;

   // One response, as the cache mirror predicts it.
   typedef struct packed {
      logic        hit;
      logic        miss;
      logic        eviction;
      logic [1:0]  hits_added;
      logic [31:0] total_hits;
      logic [31:0] total_misses;
      logic [31:0] total_evictions;
   } lookup_result_type;

   // Cache mirror: keeps its own copy of the line store, the recency ranks,
   // the registers and the counters, and checks responses in order.
   class cache_lookup_checker;
      logic                    line_valid [NUM_LINES];
      logic [ADDRESS_WIDTH-1:0] line_tag  [NUM_LINES];
      logic [RANK_W-1:0]       line_rank  [NUM_LINES];
      logic [SET_BITS_W-1:0]   set_bits;
      logic [WAYS_CFG_W-1:0]   ways_cfg;
      logic [BLOCK_BITS_W-1:0] block_bits;
      logic [31:0]             hit_total;
      logic [31:0]             miss_total;
      logic [31:0]             evict_total;
      lookup_result_type       expected_lookups [$];
      int                      failures;
      int                      reported;

      function new();
         set_bits    = SET_BITS_RESET;
         ways_cfg    = WAYS_RESET;
         block_bits  = BLOCK_BITS_RESET;
         hit_total   = '0;
         miss_total  = '0;
         evict_total = '0;
         failures    = 0;
         reported    = 0;
         invalidate_all();
      endfunction

      function void invalidate_all();
         foreach (line_valid[i]) begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_rank[i]  = '0;
         end
      endfunction

      // Any write to a real register empties the store; counters survive.
      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_SET_BITS: begin
               set_bits = value[SET_BITS_W-1:0];
               invalidate_all();
            end
            CSR_WAYS: begin
               ways_cfg = value[WAYS_CFG_W-1:0];
               invalidate_all();
            end
            CSR_BLOCK_BITS: begin
               block_bits = value[BLOCK_BITS_W-1:0];
               invalidate_all();
            end
            default: begin
            end
         endcase
      endfunction

      function int eff_set_bits();
         return (set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits);
      endfunction

      function int eff_ways();
         if (ways_cfg == 0)
            return 1;
         return (ways_cfg > MAX_WAYS) ? MAX_WAYS : int'(ways_cfg);
      endfunction

      // Make one way the most recent. Lines newer than its old rank age by
      // one; when the way was empty, every valid line ages.
      function void promote(int base, int ways, int target, bit was_valid);
         int old_rank;
         old_rank = line_rank[base + target];
         for (int w = 0; w < ways; w++) begin
            if (w != target && line_valid[base + w]) begin
               if (!was_valid || line_rank[base + w] < old_rank) begin
                  if (line_rank[base + w] < MAX_WAYS - 1)
                     line_rank[base + w] = line_rank[base + w] + 1'b1;
               end
            end
         end
         line_rank[base + target] = '0;
      endfunction

      // Runs one accepted access through the mirror and queues its response.
      function void record_access(op_type op, logic [ADDRESS_WIDTH-1:0] addr);
         int sbits, ways, bbits, shift, set_num, base;
         int found, empty, oldest, victim;
         logic [ADDRESS_WIDTH-1:0] tag;
         bit hit, evicted;
         lookup_result_type want;
         if (op == OP_FETCH)
            return;
         sbits = eff_set_bits();
         ways  = eff_ways();
         bbits = block_bits;
         set_num = int'((addr >> bbits) & ((64'd1 << sbits) - 64'd1));
         shift = sbits + bbits;
         tag = (shift >= ADDRESS_WIDTH) ? '0 : (addr >> shift);
         base = set_num * MAX_WAYS;
         found = -1;
         empty = -1;
         oldest = -1;
         hit = 1'b0;
         evicted = 1'b0;
         for (int w = 0; w < ways; w++) begin
            if (line_valid[base + w]) begin
               if (line_tag[base + w] == tag) begin
                  if (found < 0)
                     found = w;
               end else if (oldest < 0 ||
                            line_rank[base + w] > line_rank[base + oldest]) begin
                  oldest = w;
               end
            end else if (empty < 0) begin
               empty = w;
            end
         end
         if (found >= 0) begin
            hit = 1'b1;
            promote(base, ways, found, 1'b1);
         end else if (empty >= 0) begin
            promote(base, ways, empty, 1'b0);
            line_valid[base + empty] = 1'b1;
            line_tag[base + empty]   = tag;
         end else begin
            victim = (oldest < 0) ? 0 : oldest;
            evicted = 1'b1;
            promote(base, ways, victim, 1'b1);
            line_tag[base + victim] = tag;
         end
         want.hits_added = (hit ? 2'd1 : 2'd0) + ((op == OP_MODIFY) ? 2'd1 : 2'd0);
         hit_total = hit_total + 32'(want.hits_added);
         if (!hit)
            miss_total = miss_total + 32'd1;
         if (evicted)
            evict_total = evict_total + 32'd1;
         want.hit             = hit;
         want.miss            = !hit;
         want.eviction        = evicted;
         want.total_hits      = hit_total;
         want.total_misses    = miss_total;
         want.total_evictions = evict_total;
         expected_lookups.push_back(want);
      endfunction

      function int outstanding();
         return expected_lookups.size();
      endfunction

      function void report(string what, lookup_result_type want, lookup_result_type got);
         failures++;
         if (reported < MAX_REPORTS) begin
            reported++;
            $display("%0t: %s", $realtime, what);
            $display("   expected hit=%0b miss=%0b evict=%0b added=%0d totals=%0d/%0d/%0d",
                     want.hit, want.miss, want.eviction, want.hits_added,
                     want.total_hits, want.total_misses, want.total_evictions);
            $display("   actual   hit=%0b miss=%0b evict=%0b added=%0d totals=%0d/%0d/%0d",
                     got.hit, got.miss, got.eviction, got.hits_added,
                     got.total_hits, got.total_misses, got.total_evictions);
         end
      endfunction

      // Compares one accepted response with the oldest prediction.
      function void check_lookup(logic [RSP_W-1:0] data);
         lookup_result_type got, want;
         got.hit             = data[RSP_HIT_BIT];
         got.miss            = data[RSP_MISS_BIT];
         got.eviction        = data[RSP_EVICT_BIT];
         got.hits_added      = data[RSP_ADDED_LO +: 2];
         got.total_hits      = data[RSP_HITS_LO +: 32];
         got.total_misses    = data[RSP_MISSES_LO +: 32];
         got.total_evictions = data[RSP_EVICTS_LO +: 32];
         if (expected_lookups.size() == 0) begin
            report("response with no access waiting for it", '0, got);
            return;
         end
         want = expected_lookups.pop_front();
         if (got.hit !== want.hit || got.miss !== want.miss ||
             got.eviction !== want.eviction || got.hits_added !== want.hits_added ||
             got.total_hits !== want.total_hits ||
             got.total_misses !== want.total_misses ||
             got.total_evictions !== want.total_evictions)
            report("response mismatch", want, got);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata = '0;
   logic [1:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Random idling on both sides is on while this is set.
   bit idle_on = 1'b0;
   // A request for one long response-side hold-off.
   bit long_hold_req = 1'b0;

   cache_lookup_checker lookup_checker = new();

   // Address pools of the current phase. A few sets and a few more tags than
   // ways keep the sets busy, so hits and evictions both come often.
   logic [ADDRESS_WIDTH-1:0] tag_pool [12];
   int                       set_pool [4];
   int                       tag_count;
   int                       set_count;

   // Phase table; -1 picks a random value over the full register width.
   int phase_set_bits   [NUM_PHASES] = '{6, 7, 2, 6, 3, 1, 0, -1, -1, 5};
   int phase_ways       [NUM_PHASES] = '{8, 15, 0, 8, 2, 3, 1, -1, -1, 8};
   int phase_block_bits [NUM_PHASES] = '{6, 32, 63, 58, 1, 12, 40, -1, -1, 0};
   int phase_items      [NUM_PHASES] = '{150, 140, 100, 100, 150, 150, 100, 150, 150, 230};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   set_assoc_lru_cache_model dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Offers one access starting at a falling edge, sometimes after a random
   // gap, and returns at the falling edge after the request transaction.
   // tvalid stays high on return so back-to-back requests need no toggle.
   task automatic send_access(op_type op, logic [ADDRESS_WIDTH-1:0] addr);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      req_tuser  <= op;
      do
         @(posedge clock);
      while (!req_tready);
      lookup_checker.record_access(op, addr);
      @(negedge clock);
   endtask

   // Stops offering requests, waits for every predicted response and then
   // for DRAIN_CYCLES more falling edges.
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (lookup_checker.outstanding() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // One register write; returns only after the enable has dropped, so that
   // writes in a row never share a time step.
   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      lookup_checker.write_register(index, value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(int sbits, int ways, int bbits);
      wait_until_idle();
      write_csr(CSR_SET_BITS, CSR_DATA_W'(sbits));
      write_csr(CSR_WAYS, CSR_DATA_W'(ways));
      write_csr(CSR_BLOCK_BITS, CSR_DATA_W'(bbits));
   endtask

   // Places tag, set and offset where the current geometry puts them.
   function automatic logic [ADDRESS_WIDTH-1:0] build_address(
         logic [ADDRESS_WIDTH-1:0] tag, int set_num, logic [ADDRESS_WIDTH-1:0] offset);
      int sbits, bbits, shift;
      logic [ADDRESS_WIDTH-1:0] addr;
      sbits = lookup_checker.eff_set_bits();
      bbits = lookup_checker.block_bits;
      shift = sbits + bbits;
      addr = offset & ((64'd1 << bbits) - 64'd1);
      addr = addr | (64'(set_num) << bbits);
      if (shift < ADDRESS_WIDTH)
         addr = addr | (tag << shift);
      return addr;
   endfunction

   // Fresh pools for the geometry just written. Half the tags are small, so
   // they survive narrow tag fields; the rest fill all 64 bits.
   task automatic fill_pools();
      int num_sets;
      num_sets  = 1 << lookup_checker.eff_set_bits();
      set_count = $urandom_range(1, 4);
      tag_count = lookup_checker.eff_ways() + $urandom_range(0, 3);
      for (int i = 0; i < set_count; i++)
         set_pool[i] = $urandom_range(0, num_sets - 1);
      for (int i = 0; i < tag_count; i++)
         tag_pool[i] = (i % 2 == 0) ? 64'($urandom_range(0, 15)) : {$urandom, $urandom};
   endtask

   // Random accesses, fetches included, until the given number has been
   // accepted. Most reuse the pools; the rest are noise over the whole
   // address space.
   task automatic run_random(int accesses);
      int done;
      op_type op;
      logic [ADDRESS_WIDTH-1:0] addr;
      done = 0;
      while (done < accesses) begin
         op = op_type'($urandom_range(0, 3));
         if ($urandom_range(0, 9) < 8)
            addr = build_address(tag_pool[$urandom_range(0, tag_count - 1)],
                                 set_pool[$urandom_range(0, set_count - 1)],
                                 {$urandom, $urandom});
         else
            addr = {$urandom, $urandom};
         send_access(op, addr);
         done++;
      end
   endtask

   // Result checking: every response transaction is compared in order.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         lookup_checker.check_lookup(rsp_tdata);
   end

   // Response side: ready most of the time, with random stall bursts while
   // idling is on, and one long hold-off on request so the block backs up
   // and stops taking requests.
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog for a hung handshake.
   initial begin
      #(LIMIT_TIME);
      $display("FAIL set_assoc_lru_cache_model");
      $finish;
   end

   initial begin
      int sbits, ways, bbits, items;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;

      // Reset geometry: 16 sets, one way, 16-byte blocks. Offsets inside a
      // block hit, a second tag in the set evicts, and the address extremes
      // land in the first and last sets.
      send_access(OP_LOAD, 64'h0);
      send_access(OP_LOAD, 64'hF);
      send_access(OP_MODIFY, 64'h8);
      send_access(OP_STORE, 64'h10);
      send_access(OP_FETCH, 64'h0);
      send_access(OP_MODIFY, 64'h100);
      send_access(OP_LOAD, 64'h0);
      send_access(OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
      send_access(OP_STORE, 64'h8000_0000_0000_0000);
      send_access(OP_FETCH, 64'hFFFF_FFFF_FFFF_FFFF);
      send_access(OP_LOAD, 64'hFFFF_FFFF_FFFF_FFF0);

      // One fully associative set with no block offset: fill all eight ways,
      // refresh the first line, then misses must take the oldest lines.
      configure(0, 8, 0);
      for (int i = 0; i < 8; i++)
         send_access(OP_LOAD, 64'(i));
      send_access(OP_LOAD, 64'h0);
      send_access(OP_LOAD, 64'h8);
      send_access(OP_LOAD, 64'h1);
      send_access(OP_MODIFY, 64'h0);
      send_access(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF);

      for (int p = 0; p < NUM_PHASES; p++) begin
         sbits = (phase_set_bits[p] < 0) ? $urandom_range(0, 7) : phase_set_bits[p];
         ways  = (phase_ways[p] < 0) ? $urandom_range(0, 15) : phase_ways[p];
         bbits = (phase_block_bits[p] < 0) ? $urandom_range(0, 63) : phase_block_bits[p];
         items = phase_items[p];
         configure(sbits, ways, bbits);
         // One phase runs without gaps, and the last part of the run too.
         idle_on = (p != 6) && (p != NUM_PHASES - 1);
         fill_pools();
         if (p == 0)
            long_hold_req = 1'b1;
         if (p == 4) begin
            // Let everything drain mid-phase and write the spare index, which
            // must leave the warm sets alone, then carry on with them.
            run_random(items / 2);
            wait_until_idle();
            write_csr(CSR_SPARE, CSR_DATA_W'($urandom_range(0, 63)));
            run_random(items - items / 2);
         end else begin
            run_random(items);
         end
      end

      wait_until_idle();
      repeat (END_CYCLES) @(negedge clock);
      if (lookup_checker.failures == 0)
         $display("PASS set_assoc_lru_cache_model");
      else
         $display("FAIL set_assoc_lru_cache_model");
      $finish;
   end

endmodule
